### rtl/core/pld_pkg.sv
// Shared constants and types for the point-to-line distance pipeline.
package pld_pkg;

   localparam int LIMB          = 32;
   localparam int MUL_LAT       = 3;
   localparam int OUT_WIDTH     = 48;
   localparam int ROOT_IN_WIDTH = 2 * OUT_WIDTH;

   typedef struct packed {
      logic                 saturated;
      logic                 degenerate;
      logic [OUT_WIDTH-1:0] distance;
   } rsp_type;

endpackage

### rtl/core/point_to_line_distance.sv
// Throughput: one word per cycle while the output buffer is not full.
// The 96-stage divider and 48-stage root set the depth.
// A two-word output buffer decouples rsp_tready; the pipeline freezes only when it is full.
// Reset (synchronous, active high) empties the pipeline and buffer and clears take_root.
module point_to_line_distance import pld_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // point_x, point_y, point_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // distance
   output logic [OUT_WIDTH-1:0]                      rsp_tdata,
   // degenerate, saturated
   output logic [1:0]                                rsp_tuser,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic                                      csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int UW  = CW + 1;
   localparam int DM  = CW;
   localparam int PW  = UW + DM;
   localparam int CMW = 2 * CW + 1;
   localparam int DDW = 2 * CW;
   localparam int UUW = 2 * CW + 2;
   localparam int NW  = 4 * CW + 4;
   localparam int QW  = ROOT_IN_WIDTH;
   localparam int SQS = OUT_WIDTH + 3;

   logic en;
   logic take_root_ff;

   // stage 1: u = p - o
   logic signed [CW-1:0] pt [3];
   logic signed [CW-1:0] org [3];
   logic signed [UW-1:0] u_ff [3];
   logic [CW-1:0]        d_ff [3];
   logic                 v1_ff;

   // stage 2: magnitudes
   logic [UW-1:0] um_ff [3];
   logic [DM-1:0] dm_ff [3];
   logic [2:0]    opp2_ff;
   logic          v2_ff;

   // first multiplier bank
   logic [PW-1:0]     p1 [3];
   logic [PW-1:0]     p2 [3];
   logic [DDW-1:0]    sqd [3];
   logic [UUW-1:0]    squ [3];
   logic [MUL_LAT-1:0] va_ff;
   logic [2:0]        oppa_ff [MUL_LAT];

   // stage 6 / 7: cross magnitudes
   logic [PW:0]        sum6_ff [3];
   logic signed [PW:0] dif6_ff [3];
   logic [DDW-1:0]     dd6_ff;
   logic [UUW-1:0]     uu6_ff;
   logic [2:0]         opp6_ff;
   logic               v6_ff;
   logic [CMW-1:0]     cm_ff [3];
   logic [DDW-1:0]     dd7_ff;
   logic [UUW-1:0]     uu7_ff;
   logic               deg7_ff;
   logic               v7_ff;

   // second multiplier bank
   logic [2*CMW-1:0]   cs [3];
   logic [MUL_LAT-1:0] vb_ff;
   logic [MUL_LAT-1:0] degb_ff;
   logic [DDW-1:0]     ddb_ff [MUL_LAT];
   logic [UUW-1:0]     uub_ff [MUL_LAT];

   // last stage before the divider: dividend and divisor
   logic [NW-1:0]  num_ff;
   logic [DDW-1:0] den_ff;
   logic           deg10_ff;
   logic           v10_ff;

   logic           dv_valid;
   logic [QW-1:0]  quo;
   logic           dv_sat;
   logic           dv_deg;
   logic           sat_sq;
   logic [SQS-1:0] sq_side;

   logic                 rt_valid;
   logic [OUT_WIDTH-1:0] rt_root;
   logic [SQS-1:0]       rt_side;
   logic [OUT_WIDTH-1:0] rt_sq;
   logic                 rt_sat_sq;
   logic                 rt_sat_rt;
   logic                 rt_deg;

   rsp_type   res;
   rsp_type   out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;
   logic      pop;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         take_root_ff <= 1'b0;
      end else if (csr_valid) begin
         take_root_ff <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt[i]  = $signed(req_tdata[i*CW +: CW]);
         org[i] = $signed(req_tdata[(i+3)*CW +: CW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         va_ff  <= '0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         vb_ff  <= '0;
         v10_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_tvalid;
         v2_ff  <= v1_ff;
         va_ff  <= {va_ff[MUL_LAT-2:0], v2_ff};
         v6_ff  <= va_ff[MUL_LAT-1];
         v7_ff  <= v6_ff;
         vb_ff  <= {vb_ff[MUL_LAT-2:0], v7_ff};
         v10_ff <= vb_ff[MUL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i]  <= UW'(pt[i]) - UW'(org[i]);
            d_ff[i]  <= req_tdata[(i+6)*CW +: CW];
            um_ff[i] <= u_ff[i][UW-1] ? UW'(-u_ff[i]) : UW'(u_ff[i]);
            dm_ff[i] <= d_ff[i][CW-1] ? DM'(-d_ff[i]) : DM'(d_ff[i]);
            opp2_ff[i] <= (u_ff[(i+1)%3][UW-1] ^ d_ff[(i+2)%3][CW-1])
                          != (u_ff[(i+2)%3][UW-1] ^ d_ff[(i+1)%3][CW-1]);
         end
         oppa_ff[0] <= opp2_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            oppa_ff[k] <= oppa_ff[k-1];
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_mula
      pld_mul #(.AW(UW), .BW(DM)) u_p1 (
         .clock(clock), .en(en), .a(um_ff[(c+1)%3]), .b(dm_ff[(c+2)%3]), .p(p1[c])
      );
      pld_mul #(.AW(UW), .BW(DM)) u_p2 (
         .clock(clock), .en(en), .a(um_ff[(c+2)%3]), .b(dm_ff[(c+1)%3]), .p(p2[c])
      );
      pld_mul #(.AW(DM), .BW(DM)) u_sqd (
         .clock(clock), .en(en), .a(dm_ff[c]), .b(dm_ff[c]), .p(sqd[c])
      );
      pld_mul #(.AW(UW), .BW(UW)) u_squ (
         .clock(clock), .en(en), .a(um_ff[c]), .b(um_ff[c]), .p(squ[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            sum6_ff[c] <= (PW+1)'(p1[c]) + (PW+1)'(p2[c]);
            dif6_ff[c] <= (PW+1)'(p1[c]) - (PW+1)'(p2[c]);
            if (opp6_ff[c]) begin
               cm_ff[c] <= CMW'(sum6_ff[c]);
            end else if (dif6_ff[c][PW]) begin
               cm_ff[c] <= CMW'(-dif6_ff[c]);
            end else begin
               cm_ff[c] <= CMW'(dif6_ff[c]);
            end
         end
         dd6_ff  <= sqd[0] + sqd[1] + sqd[2];
         uu6_ff  <= squ[0] + squ[1] + squ[2];
         opp6_ff <= oppa_ff[MUL_LAT-1];
         dd7_ff  <= dd6_ff;
         uu7_ff  <= uu6_ff;
         deg7_ff <= (dd6_ff == '0);
         degb_ff <= {degb_ff[MUL_LAT-2:0], deg7_ff};
         ddb_ff[0] <= dd7_ff;
         uub_ff[0] <= uu7_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            ddb_ff[k] <= ddb_ff[k-1];
            uub_ff[k] <= uub_ff[k-1];
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_mulb
      pld_mul #(.AW(CMW), .BW(CMW)) u_cs (
         .clock(clock), .en(en), .a(cm_ff[c]), .b(cm_ff[c]), .p(cs[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (degb_ff[MUL_LAT-1]) begin
            num_ff <= NW'(uub_ff[MUL_LAT-1]);
            den_ff <= DDW'(1'b1);
         end else begin
            num_ff <= NW'(cs[0]) + NW'(cs[1]) + NW'(cs[2]);
            den_ff <= ddb_ff[MUL_LAT-1];
         end
         deg10_ff <= degb_ff[MUL_LAT-1];
      end
   end

   pld_div #(.NW(NW), .DW(DDW), .QW(QW), .SW(1)) u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(v10_ff),
      .num(num_ff), .den(den_ff), .side_in(deg10_ff),
      .out_valid(dv_valid), .quo(quo), .sat(dv_sat), .side_out(dv_deg)
   );

   assign sat_sq  = dv_sat || ((quo >> (FRAC_BITS + OUT_WIDTH)) != '0);
   assign sq_side = {dv_deg, dv_sat, sat_sq, quo[FRAC_BITS +: OUT_WIDTH]};

   pld_sqrt #(.IW(QW), .SW(SQS)) u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(dv_valid),
      .x(quo), .side_in(sq_side),
      .out_valid(rt_valid), .root(rt_root), .side_out(rt_side)
   );

   assign {rt_deg, rt_sat_rt, rt_sat_sq, rt_sq} = rt_side;

   always_comb begin
      res.degenerate = rt_deg;
      if (take_root_ff) begin
         res.saturated = rt_sat_rt;
         res.distance  = rt_sat_rt ? '1 : rt_root;
      end else begin
         res.saturated = rt_sat_sq;
         res.distance  = rt_sat_sq ? '1 : rt_sq;
      end
   end

   // two-word output buffer
   assign push = en && rt_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in  = cnt_ff;
      out0_in = out0_ff;
      out1_in = out1_ff;
      priority if (pop && cnt_ff == 2'd2) begin
         out0_in = out1_ff;
         cnt_in  = 2'd1;
      end else if (pop) begin
         if (push) begin
            out0_in = res;
         end else begin
            cnt_in = 2'd0;
         end
      end else if (push && cnt_ff == 2'd0) begin
         out0_in = res;
         cnt_in  = 2'd1;
      end else if (push) begin
         out1_in = res;
         cnt_in  = 2'd2;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = out0_ff.distance;
   assign rsp_tuser  = {out0_ff.saturated, out0_ff.degenerate};

endmodule

### rtl/core/pld_mul.sv
// Three-stage unsigned multiplier built from limb-sized partial products.
module pld_mul import pld_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int NA = (AW + LIMB - 1) / LIMB;
   localparam int NB = (BW + LIMB - 1) / LIMB;
   localparam int PW = AW + BW;

   logic [NA*LIMB-1:0] a_ext;
   logic [NB*LIMB-1:0] b_ext;
   logic [2*LIMB-1:0]  pp_ff [NA][NB];
   logic [PW-1:0]      row_in [NA];
   logic [PW-1:0]      row_ff [NA];
   logic [PW-1:0]      p_in;
   logic [PW-1:0]      p_ff;

   assign a_ext = (NA*LIMB)'(a);
   assign b_ext = (NB*LIMB)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_ext[i*LIMB +: LIMB] * b_ext[j*LIMB +: LIMB];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (j * LIMB));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            row_ff[i] <= row_in[i];
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         p_in = p_in + (row_ff[i] << (i * LIMB));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

### rtl/core/pld_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module pld_div import pld_pkg::*; #(
   parameter int NW = 132,
   parameter int DW = 64,
   parameter int QW = 96,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic          sat,
   output logic [SW-1:0] side_out
);

   localparam int XW = (NW > QW + DW) ? NW : QW + DW;
   localparam int HW = XW - QW;

   logic [XW-1:0] num_ext;
   logic [HW-1:0] hi;

   logic [QW:0]   v_ff;
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] lo_ff   [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic          sat_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   logic [DW:0]   trial  [QW];
   logic [DW:0]   dif    [QW];
   logic          ge     [QW];
   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] lo_in  [QW];

   assign num_ext = XW'(num);
   assign hi      = num_ext[XW-1:QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         trial[s]  = {rem_ff[s], lo_ff[s][QW-1]};
         dif[s]    = trial[s] - {1'b0, den_ff[s]};
         ge[s]     = trial[s] >= {1'b0, den_ff[s]};
         rem_in[s] = ge[s] ? dif[s][DW-1:0] : trial[s][DW-1:0];
         lo_in[s]  = {lo_ff[s][QW-2:0], ge[s]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi[DW-1:0];
         lo_ff[0]   <= num_ext[QW-1:0];
         den_ff[0]  <= den;
         sat_ff[0]  <= hi >= HW'(den);
         side_ff[0] <= side_in;
         for (int s = 0; s < QW; s++) begin
            rem_ff[s+1]  <= rem_in[s];
            lo_ff[s+1]   <= lo_in[s];
            den_ff[s+1]  <= den_ff[s];
            sat_ff[s+1]  <= sat_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign quo       = lo_ff[QW];
   assign sat       = sat_ff[QW];
   assign side_out  = side_ff[QW];

endmodule

### rtl/core/pld_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module pld_sqrt import pld_pkg::*; #(
   parameter int IW = 96,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [IW-1:0]   x,
   input  logic [SW-1:0]   side_in,
   output logic            out_valid,
   output logic [IW/2-1:0] root,
   output logic [SW-1:0]   side_out
);

   localparam int OW = IW / 2;

   logic [OW:0]   v_ff;
   logic [OW:0]   rem_ff  [OW+1];
   logic [OW-1:0] root_ff [OW+1];
   logic [IW-1:0] x_ff    [OW+1];
   logic [SW-1:0] side_ff [OW+1];

   logic [OW+2:0] trial   [OW];
   logic [OW+2:0] sub     [OW];
   logic [OW+2:0] dif     [OW];
   logic          ge      [OW];
   logic [OW:0]   rem_in  [OW];
   logic [OW-1:0] root_in [OW];

   always_comb begin
      for (int s = 0; s < OW; s++) begin
         trial[s]   = {rem_ff[s], x_ff[s][IW-1:IW-2]};
         sub[s]     = {1'b0, root_ff[s], 2'b01};
         dif[s]     = trial[s] - sub[s];
         ge[s]      = trial[s] >= sub[s];
         rem_in[s]  = ge[s] ? dif[s][OW:0] : trial[s][OW:0];
         root_in[s] = {root_ff[s][OW-2:0], ge[s]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[OW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         x_ff[0]    <= x;
         side_ff[0] <= side_in;
         for (int s = 0; s < OW; s++) begin
            rem_ff[s+1]  <= rem_in[s];
            root_ff[s+1] <= root_in[s];
            x_ff[s+1]    <= x_ff[s] << 2;
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[OW];
   assign root      = root_ff[OW];
   assign side_out  = side_ff[OW];

endmodule

### bench/tb_point_to_line_distance.sv
// Self-checking testbench for the point_to_line_distance streaming block.
module tb_point_to_line_distance import pld_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW      = 32;
   localparam int FB      = 16;
   localparam int REQ_W   = ((9*CW+7)/8)*8;
   localparam int LATENCY = 158;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_WIDTH-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_wdata = 1'b0;

   rsp_type          expected_dist_q[$];
   logic             root_mode = 1'b0;
   logic             steady = 1'b0;
   int               fail_count = 0;

   point_to_line_distance #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [139:0] coord_at(logic [REQ_W-1:0] w, int k);
      logic signed [CW-1:0] c;
      c = w[k*CW +: CW];
      return 140'(c);
   endfunction

   function automatic rsp_type line_distance(logic [REQ_W-1:0] w, logic root);
      logic signed [139:0] u[3];
      logic signed [139:0] d[3];
      logic signed [139:0] cx[3];
      logic signed [139:0] num, den, q;
      logic [139:0]         t;
      logic [47:0]          r, cand;
      rsp_type              res;
      for (int i = 0; i < 3; i++) begin
         u[i] = coord_at(w, i) - coord_at(w, 3 + i);
         d[i] = coord_at(w, 6 + i);
      end
      den = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      res.degenerate = (den == 0);
      if (res.degenerate) begin
         q = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      end else begin
         cx[0] = u[1]*d[2] - u[2]*d[1];
         cx[1] = u[2]*d[0] - u[0]*d[2];
         cx[2] = u[0]*d[1] - u[1]*d[0];
         num = cx[0]*cx[0] + cx[1]*cx[1] + cx[2]*cx[2];
         q = num / den;
      end
      if (root) begin
         res.saturated = (q >= (140'sd1 <<< 96));
         r = '0;
         if (!res.saturated) begin
            for (int b = 47; b >= 0; b--) begin
               cand = r | (48'd1 << b);
               if (140'(96'(cand) * 96'(cand)) <= q) r = cand;
            end
         end
      end else begin
         t = q >> FB;
         res.saturated = (t >> OUT_WIDTH) != 0;
         r = t[47:0];
      end
      res.distance = res.saturated ? '1 : r;
      return res;
   endfunction

   task automatic send_query(input logic [REQ_W-1:0] w);
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      expected_dist_q.push_back(line_distance(w, root_mode));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_dist_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_take_root(input logic v);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      root_mode = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [REQ_W-1:0] pack_query(
      logic [CW-1:0] px, py, pz, ox, oy, oz, dx, dy, dz);
      return {dz, dy, dx, oz, oy, ox, pz, py, px};
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      logic signed [CW-1:0] v;
      v = $urandom;
      return v >>> $urandom_range(31);
   endfunction

   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 24);

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dist_q.size() == 0) begin
            $error("unexpected rsp word: distance %0h", rsp_tdata);
            fail_count++;
         end else begin
            exp_r = expected_dist_q.pop_front();
            if (rsp_tdata !== exp_r.distance) begin
               $error("distance: expected %0h, got %0h", exp_r.distance, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== exp_r.degenerate) begin
               $error("degenerate: expected %0b, got %0b", exp_r.degenerate, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== exp_r.saturated) begin
               $error("saturated: expected %0b, got %0b", exp_r.saturated, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      localparam logic [CW-1:0] MAXP = 32'h7fff_ffff;
      localparam logic [CW-1:0] MINN = 32'h8000_0000;
      localparam logic [CW-1:0] ONE  = 32'h0001_0000;
      send_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(pack_query(ONE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(pack_query(0, ONE, 0, 0, 0, 0, ONE, 0, 0));
      send_query(pack_query(ONE, ONE, ONE, 0, 0, 0, 0, 0, ONE));
      send_query(pack_query(MAXP, MAXP, MAXP, MINN, MINN, MINN, 0, 0, 0));
      send_query(pack_query(MAXP, MAXP, MAXP, MINN, MINN, MINN, MAXP, MAXP, MAXP));
      send_query(pack_query(MAXP, 0, 0, MINN, 0, 0, 0, MINN, 0));
      send_query(pack_query(MINN, MINN, MINN, MAXP, MAXP, MAXP, MINN, 1, MAXP));
      send_query(pack_query(5, -3, 7, 0, 0, 0, 1, 1, 1));
      send_query(pack_query(-7, 2, -1, 4, 4, 4, 0, -1, 0));
      send_query(pack_query(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                            MINN, MINN, MINN));
      send_query(pack_query(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, ONE, ONE, ONE));
      send_query(pack_query(0, 32'h0100_0000, 0, 0, 0, 0, 1, 0, 0));
      send_query(pack_query(32'h00ff_ffff, 32'h00ff_ffff, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random(input int n);
      logic [CW-1:0] c[9];
      for (int k = 0; k < n; k++) begin
         steady = (k >= n/3 && k < n/3 + 80);
         for (int i = 0; i < 9; i++) c[i] = ($urandom_range(3) == 0) ? $urandom : rand_coord();
         if ($urandom_range(9) == 0) begin
            c[6] = 0; c[7] = 0; c[8] = 0;
         end
         send_query(pack_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]));
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_take_root(1'b1);
      test_directed();
      test_random(400);
      write_take_root(1'b0);
      test_random(400);
      drain_results();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("FAILURE");
      $finish;
   end

endmodule
